### src/vvp_pkg.sv
// Shared types, constants and helpers of the vertex view and projection unit.
package vvp_pkg;

	localparam int CoordW = 32;
	localparam int DiffW  = 33;
	localparam int CompW  = 16;
	localparam int AxisW  = 48;
	localparam int ProdW  = 50;
	localparam int SumW   = 52;
	localparam int ViewW  = 38;
	localparam int FocalW = 12;
	localparam int NumW   = 56;
	localparam int QBits  = 21;
	localparam int RemW   = ViewW + QBits;
	localparam int QW     = QBits + 2;
	localparam int ScrW   = 16;
	localparam int DepthW = 31;
	localparam int CfgIdxW  = 4;
	localparam int CfgDataW = 48;
	localparam int ViewLat  = 3;
	localparam int DivLat   = QBits + 2;

	typedef enum logic [CfgIdxW-1:0] {
		REG_CAM_X   = 4'd0,
		REG_CAM_Y   = 4'd1,
		REG_CAM_Z   = 4'd2,
		REG_RIGHT   = 4'd3,
		REG_UP      = 4'd4,
		REG_FRONT   = 4'd5,
		REG_FOCAL   = 4'd6,
		REG_CENTER  = 4'd7
	} cfg_reg_t;

	localparam logic [CoordW-1:0] RstCamPos = 32'd196608;
	localparam logic [AxisW-1:0]  RstRight  = 48'd16384;
	localparam logic [AxisW-1:0]  RstUp     = 48'd1073741824;
	localparam logic [AxisW-1:0]  RstFront  = 48'd211106232532992;
	localparam logic [FocalW-1:0] RstFocal  = 12'd200;
	localparam logic [31:0]       RstCenter = 32'd26215200;

	localparam logic signed [ScrW-1:0] BehindScreen = -16'sd16000;
	localparam logic [DepthW-1:0]      DepthMax     = {DepthW{1'b1}};

	typedef struct packed {
		logic              behind;
		logic [DepthW-1:0] depth;
	} side_t;

	function automatic logic signed [ScrW-1:0] sat16(input logic signed [QW:0] v);
		logic signed [QW:0] hi;
		logic signed [QW:0] lo;
		hi = (QW+1)'(32767);
		lo = -(QW+1)'(32768);
		if (v > hi) begin
			return 16'sh7fff;
		end else if (v < lo) begin
			return 16'sh8000;
		end
		return v[ScrW-1:0];
	endfunction

endpackage

### src/vvp_view.sv
// Camera-relative offset and dot products with the camera axes, three stages.
module vvp_view import vvp_pkg::*; (
	input  logic                     clk,
	input  logic                     en,
	input  logic signed [CoordW-1:0] vertex_x,
	input  logic signed [CoordW-1:0] vertex_y,
	input  logic signed [CoordW-1:0] vertex_z,
	input  logic [CoordW-1:0]        cam_x,
	input  logic [CoordW-1:0]        cam_y,
	input  logic [CoordW-1:0]        cam_z,
	input  logic [AxisW-1:0]         axis_r,
	input  logic [AxisW-1:0]         axis_u,
	input  logic [AxisW-1:0]         axis_f,
	output logic signed [ViewW-1:0]  vx,
	output logic signed [ViewW-1:0]  vy,
	output logic signed [ViewW-1:0]  vz
);

	logic signed [DiffW-1:0] t_s1 [3];
	logic signed [ProdW-1:0] p_s2 [3][3];
	logic signed [ViewW-1:0] v_s3 [3];
	logic signed [CompW:0]   a    [3][3];
	logic signed [SumW-1:0]  sum  [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			a[0][k] = $signed({axis_r[16*k+15], axis_r[16*k +: 16]});
			a[1][k] = $signed({axis_u[16*k+15], axis_u[16*k +: 16]});
			a[2][k] = -$signed({axis_f[16*k+15], axis_f[16*k +: 16]});
		end
		for (int j = 0; j < 3; j++) begin
			sum[j] = SumW'(p_s2[j][0]) + SumW'(p_s2[j][1]) + SumW'(p_s2[j][2]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_s1[0] <= DiffW'(vertex_x) - DiffW'($signed(cam_x));
			t_s1[1] <= DiffW'(vertex_y) - DiffW'($signed(cam_y));
			t_s1[2] <= DiffW'(vertex_z) - DiffW'($signed(cam_z));
			for (int j = 0; j < 3; j++) begin
				for (int k = 0; k < 3; k++) begin
					p_s2[j][k] <= ProdW'(t_s1[k] * a[j][k]);
				end
				v_s3[j] <= ViewW'(sum[j] >>> 14);
			end
		end
	end

	assign vx = v_s3[0];
	assign vy = v_s3[1];
	assign vz = v_s3[2];

endmodule

### src/vvp_div.sv
// One projection lane: focal scaling, then a pipelined restoring divide by depth.
module vvp_div import vvp_pkg::*; (
	input  logic                    clk,
	input  logic                    en,
	input  logic                    neg,
	input  logic signed [ViewW-1:0] v,
	input  logic signed [ViewW-1:0] den,
	input  logic [FocalW-1:0]       focal,
	output logic signed [QW-1:0]    q
);

	logic signed [NumW-1:0] num_s1;
	logic [ViewW-1:0]       den_s1;
	logic signed [ViewW:0]  vext;
	logic signed [16:0]     fext;
	logic [RemW-1:0]        rem_s [QBits+1];
	logic [ViewW-1:0]       dd_s  [QBits+1];
	logic [QBits-1:0]       quo_s [QBits+1];
	logic                   sgn_s [QBits+1];
	logic                   ovf_s [QBits+1];
	logic [NumW-1:0]        mag;
	logic [QBits:0]         qmag;

	assign vext = neg ? -$signed({v[ViewW-1], v}) : $signed({v[ViewW-1], v});
	assign fext = $signed({1'b0, focal, 4'b0});
	assign mag  = num_s1[NumW-1] ? NumW'(-num_s1) : NumW'(num_s1);

	always_ff @(posedge clk) begin
		if (en) begin
			num_s1   <= NumW'(vext * fext);
			den_s1   <= den;
			rem_s[0] <= RemW'(mag);
			dd_s[0]  <= den_s1;
			quo_s[0] <= '0;
			sgn_s[0] <= num_s1[NumW-1];
			ovf_s[0] <= RemW'(mag) >= {den_s1, {QBits{1'b0}}};
		end
	end

	for (genvar i = 0; i < QBits; i++) begin : g_step
		logic [RemW-1:0] shd;
		logic            ge;
		assign shd = RemW'(dd_s[i]) << (QBits - 1 - i);
		assign ge  = rem_s[i] >= shd;
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1] <= ge ? rem_s[i] - shd : rem_s[i];
				quo_s[i+1] <= {quo_s[i][QBits-2:0], ge};
				dd_s[i+1]  <= dd_s[i];
				sgn_s[i+1] <= sgn_s[i];
				ovf_s[i+1] <= ovf_s[i];
			end
		end
	end

	assign qmag = ovf_s[QBits] ? {1'b1, {QBits{1'b0}}} : {1'b0, quo_s[QBits]};
	assign q    = sgn_s[QBits] ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});

endmodule

### src/vertex_view_perspective_project_unit.sv
// Top level of the vertex view transform and perspective projection unit.
// A vertex request (vertex_x/y/z, signed Q16.16) enters on in_valid/in_ready.
// The result request (screen_x/y in Q12.4, view_depth, behind_camera) leaves
// on out_valid/out_ready. The camera registers are written through the
// cfg_valid/cfg_ready channel, cfg_index selecting the register; indexes
// above seven are ignored. cfg_ready is always high. Configuration should be
// written only while no request is inside the unit.
// One request is accepted per cycle unless the receiver stalls. In order, a
// request passes the view transform, the focal multiply, the magnitude and
// range check, the one-bit-per-stage divider and one output register.
// When the receiver stalls, the whole pipeline holds; in_ready then drops,
// and no request is lost or repeated.
// Reset empties the pipeline and loads the default camera: position (3,3,3),
// axes right (1,0,0), up (0,1,0), front (0,0,-1), focal scale 200 and screen
// center (800,400).
module vertex_view_perspective_project_unit import vvp_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic signed [CoordW-1:0] vertex_x,
	input  logic signed [CoordW-1:0] vertex_y,
	input  logic signed [CoordW-1:0] vertex_z,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [ScrW-1:0]   screen_x,
	output logic signed [ScrW-1:0]   screen_y,
	output logic [DepthW-1:0]        view_depth,
	output logic                     behind_camera,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CfgIdxW-1:0]       cfg_index,
	input  logic [CfgDataW-1:0]      cfg_data
);

	localparam int Depth = ViewLat + DivLat;

	logic [CoordW-1:0] cam_x_q, cam_y_q, cam_z_q;
	logic [AxisW-1:0]  right_q, up_q, front_q;
	logic [FocalW-1:0] focal_q;
	logic [31:0]       center_q;
	logic [Depth-1:0]  vld_q;
	side_t             side_q [DivLat];
	side_t             side_in;
	logic              adv;
	logic signed [ViewW-1:0] vx, vy, vz;
	logic signed [QW-1:0]    qx, qy;
	logic signed [QW:0]      sx, sy;

	assign adv       = !out_valid || out_ready;
	assign in_ready  = adv;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cam_x_q  <= RstCamPos;
			cam_y_q  <= RstCamPos;
			cam_z_q  <= RstCamPos;
			right_q  <= RstRight;
			up_q     <= RstUp;
			front_q  <= RstFront;
			focal_q  <= RstFocal;
			center_q <= RstCenter;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_CAM_X:  cam_x_q  <= cfg_data[CoordW-1:0];
				REG_CAM_Y:  cam_y_q  <= cfg_data[CoordW-1:0];
				REG_CAM_Z:  cam_z_q  <= cfg_data[CoordW-1:0];
				REG_RIGHT:  right_q  <= cfg_data;
				REG_UP:     up_q     <= cfg_data;
				REG_FRONT:  front_q  <= cfg_data;
				REG_FOCAL:  focal_q  <= cfg_data[FocalW-1:0];
				REG_CENTER: center_q <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	vvp_view u_view (
		.clk      (clk),
		.en       (adv),
		.vertex_x (vertex_x),
		.vertex_y (vertex_y),
		.vertex_z (vertex_z),
		.cam_x    (cam_x_q),
		.cam_y    (cam_y_q),
		.cam_z    (cam_z_q),
		.axis_r   (right_q),
		.axis_u   (up_q),
		.axis_f   (front_q),
		.vx       (vx),
		.vy       (vy),
		.vz       (vz)
	);

	vvp_div u_div_x (
		.clk   (clk),
		.en    (adv),
		.neg   (1'b0),
		.v     (vx),
		.den   (vz),
		.focal (focal_q),
		.q     (qx)
	);

	vvp_div u_div_y (
		.clk   (clk),
		.en    (adv),
		.neg   (1'b1),
		.v     (vy),
		.den   (vz),
		.focal (focal_q),
		.q     (qy)
	);

	always_comb begin
		side_in.behind = vz[ViewW-1] || (vz == '0);
		side_in.depth  = (vz[ViewW-1:DepthW] != '0) ? DepthMax : vz[DepthW-1:0];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_q[0] <= side_in;
			for (int i = 1; i < DivLat; i++) begin
				side_q[i] <= side_q[i-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			out_valid <= 1'b0;
		end else if (adv) begin
			vld_q     <= {vld_q[Depth-2:0], in_valid};
			out_valid <= vld_q[Depth-1];
		end
	end

	assign sx = (QW+1)'(qx) + $signed({4'b0, center_q[15:0], 4'b0});
	assign sy = (QW+1)'(qy) + $signed({4'b0, center_q[31:16], 4'b0});

	always_ff @(posedge clk) begin
		if (adv) begin
			if (side_q[DivLat-1].behind) begin
				screen_x      <= BehindScreen;
				screen_y      <= BehindScreen;
				view_depth    <= DepthMax;
				behind_camera <= 1'b1;
			end else begin
				screen_x      <= sat16(sx);
				screen_y      <= sat16(sy);
				view_depth    <= side_q[DivLat-1].depth;
				behind_camera <= 1'b0;
			end
		end
	end

endmodule
